/* sv/urb_pkg.sv */
// Shared types and constants for the UART ring buffer block.
// No dependencies; imported by urb_ring and the top level.
`timescale 1ns / 1ps
`default_nettype none

package urb_pkg;

    localparam int BYTE_W         = 8;
    localparam int LEVEL_W        = 7;
    localparam int OP_W           = 3;
    localparam int DEF_RING_DEPTH = 64;

    typedef enum logic [OP_W-1:0] {
        OP_RX_BYTE    = 3'd0,
        OP_HOST_READ  = 3'd1,
        OP_HOST_PEEK  = 3'd2,
        OP_HOST_WRITE = 3'd3,
        OP_TX_DONE    = 3'd4,
        OP_FLUSH_RX   = 3'd5,
        OP_FLUSH_TX   = 3'd6
    } op_t;

    // Per-beat request into one ring
    typedef struct packed {
        logic en;     // a beat is accepted this cycle
        logic put;
        logic get;
        logic flush;
        logic clear;
    } ring_req_t;

endpackage

`default_nettype wire

/* sv/urb_ring.sv */
// One overwriting byte ring: storage, head/tail/fill and registered read port.
// Depends on urb_pkg (ring_req_t, BYTE_W).
`timescale 1ns / 1ps
`default_nettype none

module urb_ring #(
    parameter int RING_DEPTH = urb_pkg::DEF_RING_DEPTH,
    parameter int FILL_W     = $clog2(RING_DEPTH + 1)
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  urb_pkg::ring_req_t           req,
    input  wire  [urb_pkg::BYTE_W-1:0]   put_data,
    output logic                         got,
    output logic [urb_pkg::BYTE_W-1:0]   rd_byte,
    output logic [FILL_W-1:0]            fill
);
    import urb_pkg::*;

    localparam int AW = $clog2(RING_DEPTH);

    logic [BYTE_W-1:0] mem [RING_DEPTH];

    logic [AW-1:0]     head_reg, head_next;
    logic [AW-1:0]     tail_reg, tail_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    // entries [0, written_reg) were written since the last clearing flush
    logic [FILL_W-1:0] written_reg, written_next;

    logic [BYTE_W-1:0] mem_q_reg;
    logic              rd_ok_reg;
    logic              fwd_reg;
    logic [BYTE_W-1:0] fwd_data_reg;

    logic              full;
    logic [AW-1:0]     tail_mid;
    logic [FILL_W-1:0] fill_mid;

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
        return (p == AW'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_comb
    begin
        full     = (fill_reg == FILL_W'(RING_DEPTH));
        // a put into a full ring drops the oldest byte first
        tail_mid = (req.put && full) ? wrap_inc(tail_reg) : tail_reg;
        fill_mid = (req.put && !full) ? fill_reg + 1'b1 : fill_reg;
        got      = req.get && (fill_mid != '0);

        head_next    = head_reg;
        tail_next    = tail_mid;
        fill_next    = fill_mid;
        written_next = written_reg;
        if (req.flush)
        begin
            head_next = '0;
            tail_next = '0;
            fill_next = '0;
            if (req.clear)
            begin
                written_next = '0;
            end
        end
        else
        begin
            if (req.put)
            begin
                head_next = wrap_inc(head_reg);
                if (FILL_W'(head_reg) == written_reg)
                begin
                    written_next = written_reg + 1'b1;
                end
            end
            if (got)
            begin
                tail_next = wrap_inc(tail_mid);
                fill_next = fill_mid - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg    <= '0;
            tail_reg    <= '0;
            fill_reg    <= '0;
            written_reg <= '0;
        end
        else if (req.en)
        begin
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            fill_reg    <= fill_next;
            written_reg <= written_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.en && req.put)
        begin
            mem[head_reg] <= put_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.en)
        begin
            mem_q_reg    <= mem[tail_mid];
            rd_ok_reg    <= (FILL_W'(tail_mid) < written_reg);
            // put and get on an empty ring hit the same entry: bypass
            fwd_reg      <= req.put && (fill_reg == '0);
            fwd_data_reg <= put_data;
        end
    end

    always_comb
    begin
        if (fwd_reg)
        begin
            rd_byte = fwd_data_reg;
        end
        else if (rd_ok_reg)
        begin
            rd_byte = mem_q_reg;
        end
        else
        begin
            rd_byte = '0;
        end
    end

    assign fill = fill_reg;

endmodule

`default_nettype wire

/* sv/uart_ring_buffers_with_tx_kick_top.sv */
// Top level: receive and transmit rings with transmitter kick logic.
// Depends on urb_pkg and urb_ring.
//
//  channel | signals                                   | dir
//  --------+-------------------------------------------+----
//  in      | in_valid/in_ready, op, data_byte,          | in
//          | clear_contents                            |
//  out     | out_valid/out_ready, read_byte, tx_start,  | out
//          | tx_byte, rx_level, tx_level               |
//
// One beat per cycle: ring pointers, counts and the memory read port all
// update at the accepting edge, and the result is in the output register
// the next cycle. A beat is taken whenever the output register is empty or
// being drained, so out_ready low stalls the input after one held result.
// Reset clears pointers and counts at once; stored bytes read as zero until
// written, tracked by a per-ring written-entry count, so no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module uart_ring_buffers_with_tx_kick_top #(
    parameter int RING_DEPTH = urb_pkg::DEF_RING_DEPTH
) (
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire                           in_valid,
    output logic                          in_ready,
    input  wire  [urb_pkg::OP_W-1:0]      op,
    input  wire  [urb_pkg::BYTE_W-1:0]    data_byte,
    input  wire                           clear_contents,
    output logic                          out_valid,
    input  wire                           out_ready,
    output logic [urb_pkg::BYTE_W-1:0]    read_byte,
    output logic                          tx_start,
    output logic [urb_pkg::BYTE_W-1:0]    tx_byte,
    output logic [urb_pkg::LEVEL_W-1:0]   rx_level,
    output logic [urb_pkg::LEVEL_W-1:0]   tx_level
);
    import urb_pkg::*;

    localparam int FILL_W = $clog2(RING_DEPTH + 1);

    logic              accept;
    ring_req_t         rx_req, tx_req;
    logic              rx_got, tx_got;
    logic [BYTE_W-1:0] rx_rd_byte, tx_rd_byte;
    logic [FILL_W-1:0] rx_fill, tx_fill;

    logic out_valid_reg;
    logic rd_sel_reg, rd_sel_next;
    logic tx_start_reg, tx_start_next;
    logic tx_idle_reg, tx_idle_next;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    // Ring requests
    always_comb
    begin
        rx_req       = '0;
        tx_req       = '0;
        rx_req.en    = accept;
        tx_req.en    = accept;
        rx_req.clear = clear_contents;
        tx_req.clear = clear_contents;
        if (accept)
        begin
            unique case (op)
                OP_RX_BYTE:
                begin
                    rx_req.put = 1'b1;
                end
                OP_HOST_READ:
                begin
                    rx_req.get = 1'b1;
                end
                OP_HOST_WRITE:
                begin
                    tx_req.put = 1'b1;
                    // kick an idle transmitter with the oldest byte
                    if (tx_idle_reg)
                    begin
                        tx_req.get = 1'b1;
                    end
                end
                OP_TX_DONE:
                begin
                    tx_req.get = 1'b1;
                end
                OP_FLUSH_RX:
                begin
                    rx_req.flush = 1'b1;
                end
                OP_FLUSH_TX:
                begin
                    tx_req.flush = 1'b1;
                end
                default:
                begin
                    // peek and unused op leave both rings alone
                end
            endcase
        end
    end

    // Result selects and transmitter state
    always_comb
    begin
        rd_sel_next   = 1'b0;
        tx_start_next = 1'b0;
        tx_idle_next  = tx_idle_reg;
        if (accept)
        begin
            unique case (op)
                OP_HOST_READ:
                begin
                    rd_sel_next = rx_got;
                end
                OP_HOST_PEEK:
                begin
                    rd_sel_next = 1'b1;
                end
                OP_HOST_WRITE:
                begin
                    if (tx_idle_reg)
                    begin
                        tx_start_next = 1'b1;
                        tx_idle_next  = 1'b0;
                    end
                end
                OP_TX_DONE:
                begin
                    tx_start_next = tx_got;
                    if (!tx_got)
                    begin
                        tx_idle_next = 1'b1;
                    end
                end
                default:
                begin
                    // put, flushes and unused op: report levels only
                end
            endcase
        end
    end

    urb_ring #(
        .RING_DEPTH (RING_DEPTH),
        .FILL_W     (FILL_W)
    ) u_rx_ring (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (rx_req),
        .put_data (data_byte),
        .got      (rx_got),
        .rd_byte  (rx_rd_byte),
        .fill     (rx_fill)
    );

    urb_ring #(
        .RING_DEPTH (RING_DEPTH),
        .FILL_W     (FILL_W)
    ) u_tx_ring (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (tx_req),
        .put_data (data_byte),
        .got      (tx_got),
        .rd_byte  (tx_rd_byte),
        .fill     (tx_fill)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            rd_sel_reg    <= 1'b0;
            tx_start_reg  <= 1'b0;
            tx_idle_reg   <= 1'b1;
        end
        else
        begin
            if (in_ready)
            begin
                out_valid_reg <= in_valid;
            end
            if (accept)
            begin
                rd_sel_reg   <= rd_sel_next;
                tx_start_reg <= tx_start_next;
                tx_idle_reg  <= tx_idle_next;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign read_byte = rd_sel_reg ? rx_rd_byte : '0;
    assign tx_start  = tx_start_reg;
    assign tx_byte   = tx_start_reg ? tx_rd_byte : '0;
    assign rx_level  = LEVEL_W'(rx_fill);
    assign tx_level  = LEVEL_W'(tx_fill);

    // Checks

    a_rx_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rx_fill <= FILL_W'(RING_DEPTH))
        else $error("rx fill exceeds ring depth");

    a_kick_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && op == OP_HOST_WRITE) |=> !tx_idle_reg)
        else $error("transmitter idle after host write");

    a_flush_rx: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && op == OP_FLUSH_RX) |=> (rx_fill == '0))
        else $error("rx ring not empty after flush");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && tx_start_reg) |-> !tx_idle_reg)
        else $error("tx start reported while transmitter idle");

endmodule

`default_nettype wire

/* tb/tb_uart_ring_buffers_with_tx_kick_top.sv */
// Self-checking testbench for the UART ring buffer block with transmit kick.
// Depends on urb_pkg and the uart_ring_buffers_with_tx_kick_top RTL; an in-bench
// ring predictor checks every result beat in order.
`timescale 1ns / 1ps

module tb_uart_ring_buffers_with_tx_kick_top;

    import urb_pkg::*;

    localparam int           DEPTH       = DEF_RING_DEPTH;
    localparam int           RX_RING     = 0;
    localparam int           TX_RING     = 1;
    localparam logic [2:0]   OP_UNUSED   = 3'd7;
    localparam int           MIX_FILL    = 0;
    localparam int           MIX_DRAIN   = 1;
    localparam int           MIX_EVEN    = 2;
    localparam int           STALL_LIMIT = 1000;
    localparam int           HOLD_CYCLES = 80;

    typedef struct packed {
        logic [BYTE_W-1:0]  rd;
        logic               start;
        logic [BYTE_W-1:0]  txb;
        logic [LEVEL_W-1:0] rxl;
        logic [LEVEL_W-1:0] txl;
    } ring_result_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [OP_W-1:0]    op;
    logic [BYTE_W-1:0]  data_byte;
    logic               clear_contents;
    logic               out_valid;
    logic               out_ready;
    logic [BYTE_W-1:0]  read_byte;
    logic               tx_start;
    logic [BYTE_W-1:0]  tx_byte;
    logic [LEVEL_W-1:0] rx_level;
    logic [LEVEL_W-1:0] tx_level;

    // Predictor state: index 0 is the receive ring, index 1 the transmit ring
    logic [BYTE_W-1:0]  ring_mem  [2][DEPTH];
    int                 ring_head [2];
    int                 ring_tail [2];
    int                 ring_fill [2];
    logic               tx_is_idle;

    ring_result_t       due_results[$];
    int                 errors;
    int                 beats_in;
    int                 beats_out;
    int                 stall_cycles;
    int                 hold_request;
    bit                 send_gaps;
    bit                 out_gaps;

    uart_ring_buffers_with_tx_kick_top u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .op             (op),
        .data_byte      (data_byte),
        .clear_contents (clear_contents),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .read_byte      (read_byte),
        .tx_start       (tx_start),
        .tx_byte        (tx_byte),
        .rx_level       (rx_level),
        .tx_level       (tx_level)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int ptr_next(int p);
        return (p == DEPTH - 1) ? 0 : p + 1;
    endfunction

    function automatic void ring_put(int r, logic [BYTE_W-1:0] b);
        ring_mem[r][ring_head[r]] = b;
        ring_head[r] = ptr_next(ring_head[r]);
        // full ring: drop the oldest byte
        if (ring_fill[r] < DEPTH)
            ring_fill[r]++;
        else
            ring_tail[r] = ptr_next(ring_tail[r]);
    endfunction

    function automatic logic [BYTE_W-1:0] ring_get(int r);
        logic [BYTE_W-1:0] b;
        if (ring_fill[r] == 0)
            return '0;
        b = ring_mem[r][ring_tail[r]];
        ring_tail[r] = ptr_next(ring_tail[r]);
        ring_fill[r]--;
        return b;
    endfunction

    function automatic void ring_flush(int r, logic clr);
        ring_head[r] = 0;
        ring_tail[r] = 0;
        ring_fill[r] = 0;
        if (clr)
        begin
            for (int i = 0; i < DEPTH; i++)
                ring_mem[r][i] = '0;
        end
    endfunction

    function automatic ring_result_t next_ring_result(logic [OP_W-1:0] code,
                                                      logic [BYTE_W-1:0] data, logic clr);
        ring_result_t res;
        res = '0;
        case (code)
            OP_RX_BYTE:    ring_put(RX_RING, data);
            OP_HOST_READ:  res.rd = ring_get(RX_RING);
            OP_HOST_PEEK:  res.rd = ring_mem[RX_RING][ring_tail[RX_RING]];
            OP_HOST_WRITE:
            begin
                ring_put(TX_RING, data);
                if (tx_is_idle)
                begin
                    tx_is_idle = 1'b0;
                    res.txb    = ring_get(TX_RING);
                    res.start  = 1'b1;
                end
            end
            OP_TX_DONE:
            begin
                if (ring_fill[TX_RING] > 0)
                begin
                    res.txb   = ring_get(TX_RING);
                    res.start = 1'b1;
                end
                else
                    tx_is_idle = 1'b1;
            end
            OP_FLUSH_RX:   ring_flush(RX_RING, clr);
            OP_FLUSH_TX:   ring_flush(TX_RING, clr);
            default:       ;
        endcase
        res.rxl = ring_fill[RX_RING][LEVEL_W-1:0];
        res.txl = ring_fill[TX_RING][LEVEL_W-1:0];
        return res;
    endfunction

    task automatic report_mismatch(input string field, input int want, input int got);
        $display("MISMATCH %s at result %0d: expected %0d, got %0d (t=%0t)",
                 field, beats_out, want, got, $time);
        errors++;
    endtask

    // Offer one beat, hold it until accepted, then log the expected result
    task automatic send_item(input logic [OP_W-1:0] code, input logic [BYTE_W-1:0] data,
                             input logic clr);
        if (send_gaps && $urandom_range(99) < 12)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid       <= 1'b1;
        op             <= code;
        data_byte      <= data;
        clear_contents <= clr;
        do
            @(posedge clk);
        while (!in_ready);
        due_results.push_back(next_ring_result(code, data, clr));
        beats_in++;
    endtask

    task automatic wait_results_drained();
        in_valid <= 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [OP_W-1:0] pick_op(int mix);
        int w;
        int p_put;
        int p_read;
        int p_write;
        int p_done;
        case (mix)
            MIX_FILL:  begin p_put = 42; p_read = 8;  p_write = 26; p_done = 8;  end
            MIX_DRAIN: begin p_put = 8;  p_read = 42; p_write = 8;  p_done = 26; end
            default:   begin p_put = 21; p_read = 21; p_write = 21; p_done = 21; end
        endcase
        w = $urandom_range(99);
        if (w < p_put) return OP_RX_BYTE;
        w -= p_put;
        if (w < p_read) return OP_HOST_READ;
        w -= p_read;
        if (w < p_write) return OP_HOST_WRITE;
        w -= p_write;
        if (w < p_done) return OP_TX_DONE;
        w -= p_done;
        if (w < 8) return OP_HOST_PEEK;
        w -= 8;
        if (w < 2) return OP_FLUSH_RX;
        w -= 2;
        if (w < 2) return OP_FLUSH_TX;
        return OP_UNUSED;
    endfunction

    // Empty reads, stale and cleared peeks, tx kick and idle, flushes, unused op
    task automatic test_directed_cases();
        send_item(OP_HOST_PEEK,  8'h00, 1'b0);
        send_item(OP_HOST_READ,  8'hFF, 1'b1);
        send_item(OP_TX_DONE,    8'h00, 1'b0);
        send_item(OP_RX_BYTE,    8'hFF, 1'b0);
        send_item(OP_RX_BYTE,    8'h00, 1'b1);
        send_item(OP_HOST_PEEK,  8'h00, 1'b0);
        send_item(OP_HOST_READ,  8'h00, 1'b0);
        send_item(OP_HOST_READ,  8'h00, 1'b0);
        send_item(OP_HOST_READ,  8'h00, 1'b0);
        send_item(OP_FLUSH_RX,   8'h00, 1'b0);
        send_item(OP_HOST_PEEK,  8'h00, 1'b0);
        send_item(OP_FLUSH_RX,   8'hFF, 1'b1);
        send_item(OP_HOST_PEEK,  8'h00, 1'b0);
        send_item(OP_HOST_WRITE, 8'h5A, 1'b0);
        send_item(OP_HOST_WRITE, 8'hA5, 1'b1);
        send_item(OP_HOST_WRITE, 8'h01, 1'b0);
        send_item(OP_FLUSH_TX,   8'h00, 1'b0);
        send_item(OP_TX_DONE,    8'h00, 1'b0);
        send_item(OP_TX_DONE,    8'hFF, 1'b1);
        send_item(OP_HOST_WRITE, 8'h80, 1'b0);
        send_item(OP_FLUSH_TX,   8'h00, 1'b1);
        send_item(OP_UNUSED,     8'hFF, 1'b1);
        send_item(OP_RX_BYTE,    8'h7E, 1'b0);
        send_item(OP_UNUSED,     8'h00, 1'b0);
        send_item(OP_FLUSH_TX,   8'h00, 1'b0);
    endtask

    // Push both rings past full so the oldest bytes get overwritten, then drain
    task automatic test_ring_overwrite();
        for (int i = 0; i < DEPTH + 6; i++)
            send_item(OP_RX_BYTE, BYTE_W'($urandom_range(255)), 1'($urandom_range(1)));
        send_item(OP_HOST_PEEK, BYTE_W'($urandom_range(255)), 1'($urandom_range(1)));
        for (int i = 0; i < DEPTH + 2; i++)
            send_item(OP_HOST_READ, BYTE_W'($urandom_range(255)), 1'($urandom_range(1)));
        for (int i = 0; i < DEPTH + 7; i++)
            send_item(OP_HOST_WRITE, BYTE_W'($urandom_range(255)), 1'($urandom_range(1)));
        for (int i = 0; i < DEPTH + 2; i++)
            send_item(OP_TX_DONE, BYTE_W'($urandom_range(255)), 1'($urandom_range(1)));
    endtask

    // Long receiver hold while the sender keeps offering, then a full drain
    task automatic test_output_stall();
        send_gaps    = 1'b0;
        hold_request = HOLD_CYCLES;
        for (int i = 0; i < 40; i++)
            send_item(pick_op(MIX_EVEN), BYTE_W'($urandom_range(255)),
                      1'($urandom_range(1)));
        wait_results_drained();
        send_gaps = 1'b1;
    endtask

    task automatic test_random_traffic();
        int mix;
        mix       = MIX_EVEN;
        send_gaps = 1'b0;
        out_gaps  = 1'b0;
        for (int i = 0; i < 1500; i++)
        begin
            if (i == 250)
            begin
                send_gaps = 1'b1;
                out_gaps  = 1'b1;
            end
            if (i % 60 == 0)
                mix = $urandom_range(MIX_EVEN);
            send_item(pick_op(mix), BYTE_W'($urandom_range(255)), 1'($urandom_range(1)));
        end
    endtask

    initial
    begin : receiver
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_request > 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else
                out_ready <= !(out_gaps && $urandom_range(99) < 12);
        end
    end

    always @(posedge clk)
    begin : result_check
        ring_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (due_results.size() == 0)
                report_mismatch("unexpected result beat", 0, 1);
            else
            begin
                want = due_results.pop_front();
                if (read_byte !== want.rd)  report_mismatch("read_byte", want.rd, read_byte);
                if (tx_start !== want.start)
                    report_mismatch("tx_start", want.start, tx_start);
                if (tx_byte !== want.txb)   report_mismatch("tx_byte", want.txb, tx_byte);
                if (rx_level !== want.rxl)  report_mismatch("rx_level", want.rxl, rx_level);
                if (tx_level !== want.txl)  report_mismatch("tx_level", want.txl, tx_level);
            end
            beats_out++;
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Watchdog: no beat moved in %0d cycles, %0d results outstanding",
                     STALL_LIMIT, due_results.size());
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        op             = '0;
        data_byte      = '0;
        clear_contents = 1'b0;
        out_ready      = 1'b0;
        errors         = 0;
        beats_in       = 0;
        beats_out      = 0;
        stall_cycles   = 0;
        hold_request   = 0;
        send_gaps      = 1'b1;
        out_gaps       = 1'b1;
        tx_is_idle     = 1'b1;
        ring_flush(RX_RING, 1'b1);
        ring_flush(TX_RING, 1'b1);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        wait_results_drained();
        test_ring_overwrite();
        test_output_stall();
        test_random_traffic();
        wait_results_drained();
        repeat (10) @(posedge clk);

        $display("Sent %0d beats, checked %0d results: empty reads, stale peeks, overwrite,",
                 beats_in, beats_out);
        $display("tx kick and idle, clearing and plain flushes, unused op, output stalls.");
        if (errors == 0 && due_results.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

/* uart_ring_buffers_with_tx_kick_top.f */
sv/urb_pkg.sv
sv/urb_ring.sv
sv/uart_ring_buffers_with_tx_kick_top.sv
tb/tb_uart_ring_buffers_with_tx_kick_top.sv
